// ----- rtl/lisl_pkg.sv -----
// Shared beat types and constants for the longest increasing subsequence block.
package lisl_pkg;

    // Flipping the sign bit turns signed order into unsigned order.
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    // Largest length the 11-bit result field can report.
    localparam logic [10:0] LEN_MAX = 11'd2047;

    typedef struct packed {
        logic signed [31:0] value;
        logic               first;
    } t_in_beat;

    typedef struct packed {
        logic [10:0] length;
        logic        full_res;
    } t_out_beat;

endpackage

// ----- rtl/longest_increasing_subsequence_length_top.sv -----
// Top level of the streaming longest strictly increasing subsequence length block.
// Each search step has a check state, which issues a read on the single tails read port,
// and a compare state, which narrows the range using the returned tail.
// The block works on one item at a time; the next input beat is taken once the item
// in work has handed its result to the output register.
// Reset (synchronous, active low) empties the sequence; the tails store is not cleared.
module longest_increasing_subsequence_length_top #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lisl_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lisl_pkg::t_out_beat o_out_data
);

    import lisl_pkg::*;

    localparam int unsigned IW = $clog2(CAPACITY);

    logic          eng_idle;
    logic          res_valid;
    logic          res_ready;
    t_out_beat     res;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic          r_out_valid;
    t_out_beat     r_out_data;

    // The sequencer takes a new beat only while it is idle. A finished result
    // moves into the output register, so the next search may begin while the
    // previous result still waits downstream.
    assign o_in_ready = eng_idle;

    // The output register can take a result when empty or draining this cycle.
    assign res_ready = !r_out_valid || i_out_ready;

    lisl_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid),
        .i_item      (i_in_data),
        .o_idle      (eng_idle),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Tails are stored with the sign bit flipped, so an unsigned compare in
    // the sequencer follows signed order exactly.
    lisl_tails_ram #(
        .CAPACITY (CAPACITY)
    ) u_tails (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Output register for the result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/lisl_tails_ram.sv -----
// Tails store: one write port and one read port with registered read data.
module lisl_tails_ram #(
    parameter int unsigned CAPACITY = 1024,
    localparam int unsigned IW = $clog2(CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data
);

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lisl_engine.sv -----
// Search sequencer: binary search over the tails store with one shared comparator.
module lisl_engine #(
    parameter int unsigned CAPACITY = 1024,
    localparam int unsigned IW = $clog2(CAPACITY),
    localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lisl_pkg::t_in_beat i_item,
    output logic              o_idle,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output lisl_pkg::t_out_beat o_res,
    output logic              o_rd_en,
    output logic [IW-1:0]     o_rd_addr,
    input  logic [31:0]       i_rd_data,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_addr,
    output logic [31:0]       o_wr_data
);

    import lisl_pkg::*;

    localparam int unsigned OW = (LW > 11) ? LW : 11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_UPD
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_lo, n_lo;
    logic [LW-1:0] r_hi, n_hi;
    logic [LW-1:0] r_mid, n_mid;
    logic [31:0]   r_key, n_key;

    logic [LW-1:0] mid;
    logic          hit;
    logic          room;
    logic [LW-1:0] upd_len;
    logic [OW-1:0] len_wide;

    assign mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign hit  = (r_lo < r_len);
    assign room = (r_len < LW'(CAPACITY));

    always_comb begin
        if (hit) begin
            upd_len = r_len;
        end else if (room) begin
            upd_len = LW'(r_len + 1'b1);
        end else begin
            upd_len = r_len;
        end
    end

    assign len_wide = OW'(upd_len);

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        o_rd_en = 1'b0;
        o_wr_en = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_key   = i_item.value ^ SIGN_FLIP;
                    n_len   = i_item.first ? '0 : r_len;
                    n_lo    = '0;
                    n_hi    = n_len;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_lo < r_hi) begin
                    o_rd_en = 1'b1;
                    n_mid   = mid;
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_UPD;
                end
            end
            ST_CMP: begin
                if (i_rd_data < r_key) begin
                    n_lo = LW'(r_mid + 1'b1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = ST_CHECK;
            end
            ST_UPD: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    o_wr_en     = hit || room;
                    n_len       = upd_len;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    // When the search ends past the last tail, lo equals the length, so the
    // same address serves both replacement and extension.
    assign o_rd_addr = mid[IW-1:0];
    assign o_wr_addr = r_lo[IW-1:0];
    assign o_wr_data = r_key;
    assign o_idle    = (r_state == ST_IDLE);

    assign o_res.length   = (len_wide > OW'(LEN_MAX)) ? LEN_MAX : len_wide[10:0];
    assign o_res.full_res = !hit && !room;

endmodule

// ----- test/tb_longest_increasing_subsequence_length_top.sv -----
// Self-checking testbench for the streaming longest increasing subsequence length block.
module tb_longest_increasing_subsequence_length_top;

    import lisl_pkg::*;

    // The block is checked at its default capacity, so the store-full test
    // really fills all 1024 tails.
    localparam int CAP = 1024;

    localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_SENT = 32'sh3f3f_3f3f;

    // Percentage of cycles in which each side holds back.
    localparam int IDLE_PCT = 28;

    // Extra cycles after the last result before a phase is treated as idle.
    localparam int SETTLE_CYCLES = 40;

    // Shapes of random content within one well-formed run.
    typedef enum int {
        PAT_UNIFORM,
        PAT_NARROW,
        PAT_RISING,
        PAT_SENTINEL,
        PAT_EDGES
    } t_pattern;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    longest_increasing_subsequence_length_top #(
        .CAPACITY(CAP)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the block: the tails of the current run and its length.
    logic signed [31:0] lis_tails [CAP];
    int                 lis_len = 0;

    // Expected result beats, oldest first.
    t_out_beat expected_lengths [$];

    // While set, neither the sender nor the receiver holds back.
    logic steady_flow = 1'b0;

    int errors     = 0;
    int items_sent = 0;
    int beats_seen = 0;
    int full_seen  = 0;

    // Works out the result of one input beat and updates the shadow state.
    // The search finds the first tail that is not smaller than the value;
    // tails at or beyond the current length count as plus infinity.
    function automatic t_out_beat lis_predict(input t_in_beat beat);
        int        lo;
        int        hi;
        int        mid;
        t_out_beat res;
        if (beat.first)
            lis_len = 0;
        lo = 0;
        hi = lis_len;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if ($signed(lis_tails[mid]) < $signed(beat.value))
                lo = mid + 1;
            else
                hi = mid;
        end
        res.full_res = 1'b0;
        if (lo < lis_len) begin
            // Replacing with an equal value leaves the store as it was.
            lis_tails[lo] = beat.value;
        end else if (lis_len < CAP) begin
            lis_tails[lis_len] = beat.value;
            lis_len++;
        end else begin
            // The run would grow past the store, so the value is dropped.
            res.full_res = 1'b1;
        end
        res.length = (lis_len > int'(LEN_MAX)) ? LEN_MAX : 11'(lis_len);
        return res;
    endfunction

    // The receiver stalls at random unless a steady stretch is running.
    always @(posedge i_clk)
        i_out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

    // Every result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (o_out_data.full_res)
                full_seen++;
            if (expected_lengths.size() == 0) begin
                $error("unexpected result beat: length %0d full_res %0b",
                       o_out_data.length, o_out_data.full_res);
                errors++;
            end else begin
                want = expected_lengths.pop_front();
                if (o_out_data.length !== want.length) begin
                    $error("length: expected %0d, actual %0d",
                           want.length, o_out_data.length);
                    errors++;
                end
                if (o_out_data.full_res !== want.full_res) begin
                    $error("full_res: expected %0b, actual %0b",
                           want.full_res, o_out_data.full_res);
                    errors++;
                end
            end
        end
    end

    // Sends one beat. Valid stays high after the handshake so that a
    // following beat can go out back to back; it is lowered only in a gap
    // or when the stream drains.
    task automatic send_item(input logic signed [31:0] val, input logic first_mark);
        t_in_beat beat;
        beat.value = val;
        beat.first = first_mark;
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        expected_lengths = {expected_lengths, lis_predict(beat)};
        items_sent++;
    endtask

    // Holds the sender back until every expected result has come out, then
    // lets the block settle.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (expected_lengths.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Field extremes, values around the old finite sentinel, equal values,
    // and the very first item after reset arriving without a first mark.
    task automatic test_directed_values();
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(VAL_SENT, 1'b0);
        send_item(VAL_SENT - 1, 1'b0);
        send_item(VAL_SENT + 1, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(VAL_SENT, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MIN, 1'b1);
        send_item(32'sd100, 1'b0);
        send_item(32'sd50, 1'b0);
        send_item(-32'sd10, 1'b0);
        send_item(-32'sd100, 1'b0);
        send_item(32'sd0, 1'b1);
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd3, 1'b0);
        wait_until_drained();
    endtask

    // Fills every tail with a strictly rising run, then pushes past the
    // capacity, tries equal and smaller values on a full store, and finally
    // restarts with a first mark. The first half runs without any idling.
    task automatic test_store_full();
        longint step;
        int     k;
        step = (64'sd1 <<< 32) / (CAP + 1);
        steady_flow = 1'b1;
        for (k = 0; k < CAP; k++) begin
            if (k == CAP / 2)
                steady_flow = 1'b0;
            send_item(32'(longint'(VAL_MIN) + k * step), k == 0);
        end
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(32'(longint'(VAL_MIN) + 5 * step), 1'b0);
        send_item(32'(longint'(VAL_MIN) + 7 * step - 1), 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MIN, 1'b0);
        wait_until_drained();
    endtask

    // Random runs, each normally opened by a first mark, with content shaped
    // to exercise replacing, equal values and long growth. A few runs lack
    // the opening mark or carry stray marks in the middle.
    task automatic test_random_runs(input int n_items);
        int                 sent;
        int                 run_len;
        int                 k;
        t_pattern           pat;
        logic signed [31:0] base;
        logic signed [31:0] val;
        logic               mark;
        sent = 0;
        while (sent < n_items) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(200, 60)
                                               : $urandom_range(40, 1);
            pat  = t_pattern'($urandom_range(int'(PAT_EDGES)));
            base = $urandom;
            for (k = 0; k < run_len && sent < n_items; k++) begin
                case (pat)
                    PAT_UNIFORM:  val = $urandom;
                    PAT_NARROW:   val = $signed($urandom_range(15)) - 8;
                    PAT_RISING:   val = base + k * $urandom_range(1000)
                                        - $urandom_range(3000);
                    PAT_SENTINEL: val = VAL_SENT + $signed($urandom_range(6)) - 3;
                    default:      val = $urandom_range(1) ? VAL_MAX - $urandom_range(3)
                                                          : VAL_MIN + $urandom_range(3);
                endcase
                mark = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                send_item(val, mark);
                sent++;
            end
            // Once midway the sender waits for the block to empty completely.
            if (sent >= n_items / 2 && sent - run_len < n_items / 2)
                wait_until_drained();
        end
        wait_until_drained();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_values();
        test_store_full();
        test_random_runs(546);

        $display("Covered %0d input beats and %0d result beats, %0d of them on a full store.",
                 items_sent, beats_seen, full_seen);
        $display("Runs included field extremes, equal values and a full fill of %0d tails.",
                 CAP);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guards against a hung handshake; far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results still outstanding.", expected_lengths.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lisl_pkg.sv
rtl/lisl_tails_ram.sv
rtl/lisl_engine.sv
rtl/longest_increasing_subsequence_length_top.sv
test/tb_longest_increasing_subsequence_length_top.sv
